// ===== rtl/core/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg: shared constants for the flat index to coordinates converter
// Default widths, dimension count and configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

	// Number of coordinate outputs and size registers
	localparam int MAX_DIMS       = 4;

	// Default widths of the index and of one coordinate
	localparam int INDEX_BITS_DEF = 32;
	localparam int COORD_BITS_DEF = 16;

	// Dimension count register
	localparam int NUM_DIMS_BITS  = 3;
	localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RESET = 3'd4;

	// Configuration register index
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_NUM_DIMS  = 3'd0,
		REG_SIZE_DIM0 = 3'd1,
		REG_SIZE_DIM1 = 3'd2,
		REG_SIZE_DIM2 = 3'd3,
		REG_SIZE_DIM3 = 3'd4
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftc_index_if.sv =====
// ----------------------------------------------------------------------------
// ftc_index_if: flat index channel
// Valid/ready channel that carries one row-major flat index per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftc_index_if #(
	parameter int INDEX_BITS = ftc_pkg::INDEX_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] flat_index;

	modport source (output valid, output flat_index, input ready);
	modport sink   (input valid, input flat_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ftc_coord_if.sv =====
// ----------------------------------------------------------------------------
// ftc_coord_if: coordinate channel
// Valid/ready channel that carries one set of four coordinates per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftc_coord_if #(
	parameter int COORD_BITS = ftc_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] coord0;
	logic [COORD_BITS-1:0] coord1;
	logic [COORD_BITS-1:0] coord2;
	logic [COORD_BITS-1:0] coord3;

	modport source (output valid, output coord0, output coord1, output coord2,
		output coord3, input ready);
	modport sink   (input valid, input coord0, input coord1, input coord2,
		input coord3, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ftc_div_bit.sv =====
// ----------------------------------------------------------------------------
// ftc_div_bit: one restoring division step with its pipeline register
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in. Coordinates ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_div_bit #(
	parameter int COORD_BITS = ftc_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = ftc_pkg::INDEX_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic [COORD_BITS-1:0]                         divisor,
	input  logic                                          up_valid,
	input  logic [COORD_BITS-1:0]                         up_rem,
	input  logic [INDEX_BITS-1:0]                         up_quo,
	input  logic [COORD_BITS-1:0]                         up_orig,
	input  logic [ftc_pkg::MAX_DIMS-1:0][COORD_BITS-1:0] up_coord,
	output logic                                          dn_valid,
	output logic [COORD_BITS-1:0]                         dn_rem,
	output logic [INDEX_BITS-1:0]                         dn_quo,
	output logic [COORD_BITS-1:0]                         dn_orig,
	output logic [ftc_pkg::MAX_DIMS-1:0][COORD_BITS-1:0] dn_coord
);
	import ftc_pkg::*;

	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  take;
	logic [COORD_BITS-1:0] rem_nxt;
	logic [INDEX_BITS-1:0] quo_nxt;

	logic                                 valid_s1;
	logic [COORD_BITS-1:0]                rem_s1;
	logic [INDEX_BITS-1:0]                quo_s1;
	logic [COORD_BITS-1:0]                orig_s1;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_s1;

	// Bring down the next dividend bit and try the subtract
	always_comb begin
		trial   = {up_rem, up_quo[INDEX_BITS-1]};
		diff    = trial - {1'b0, divisor};
		take    = (trial >= {1'b0, divisor});
		rem_nxt = take ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
		quo_nxt = {up_quo[INDEX_BITS-2:0], take};
	end

	// Advance the valid bit with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
		end
	end

	// Advance the payload; hold it on a stall
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1   <= rem_nxt;
			quo_s1   <= quo_nxt;
			orig_s1  <= up_orig;
			coord_s1 <= up_coord;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_rem   = rem_s1;
	assign dn_quo   = quo_s1;
	assign dn_orig  = orig_s1;
	assign dn_coord = coord_s1;

endmodule

`default_nettype wire

// ===== rtl/core/ftc_dim_pass.sv =====
// ----------------------------------------------------------------------------
// ftc_dim_pass: one dimension of the unravel
// A chain of division steps, one quotient bit per stage, splits the running
// index into remainder (the coordinate) and quotient (the next running index).
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_dim_pass #(
	parameter int COORD_BITS = ftc_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = ftc_pkg::INDEX_BITS_DEF,
	parameter int DIM        = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic [COORD_BITS-1:0]                         divisor,
	input  logic                                          up_valid,
	input  logic [INDEX_BITS-1:0]                         up_run,
	input  logic [ftc_pkg::MAX_DIMS-1:0][COORD_BITS-1:0] up_coord,
	output logic                                          dn_valid,
	output logic [INDEX_BITS-1:0]                         dn_run,
	output logic [ftc_pkg::MAX_DIMS-1:0][COORD_BITS-1:0] dn_coord
);
	import ftc_pkg::*;

	logic                                 valid_w [INDEX_BITS+1];
	logic [COORD_BITS-1:0]                rem_w   [INDEX_BITS+1];
	logic [INDEX_BITS-1:0]                quo_w   [INDEX_BITS+1];
	logic [COORD_BITS-1:0]                orig_w  [INDEX_BITS+1];
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_w [INDEX_BITS+1];

	// Start a fresh division: empty remainder, dividend in the quotient
	assign valid_w[0] = up_valid;
	assign rem_w[0]   = '0;
	assign quo_w[0]   = up_run;
	assign orig_w[0]  = COORD_BITS'(up_run);
	assign coord_w[0] = up_coord;

	for (genvar b = 0; b < INDEX_BITS; b++) begin : g_bit
		ftc_div_bit #(
			.COORD_BITS (COORD_BITS),
			.INDEX_BITS (INDEX_BITS)
		) u_bit (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (divisor),
			.up_valid (valid_w[b]),
			.up_rem   (rem_w[b]),
			.up_quo   (quo_w[b]),
			.up_orig  (orig_w[b]),
			.up_coord (coord_w[b]),
			.dn_valid (valid_w[b+1]),
			.dn_rem   (rem_w[b+1]),
			.dn_quo   (quo_w[b+1]),
			.dn_orig  (orig_w[b+1]),
			.dn_coord (coord_w[b+1])
		);
	end

	// Write this dimension's coordinate; a zero size passes the low bits of the index through
	always_comb begin
		dn_valid = valid_w[INDEX_BITS];
		dn_coord = coord_w[INDEX_BITS];
		if (divisor == '0) begin
			dn_coord[DIM] = orig_w[INDEX_BITS];
			dn_run        = '0;
		end else begin
			dn_coord[DIM] = rem_w[INDEX_BITS];
			dn_run        = quo_w[INDEX_BITS];
		end
	end

	// Remainder of a real division stays below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_w[INDEX_BITS] && divisor != '0 |-> rem_w[INDEX_BITS] < divisor)
		else $error("ftc_dim_pass: remainder not below divisor");

	// Division by one leaves no remainder at the end of the chain
	a_unit_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_w[INDEX_BITS] && divisor == COORD_BITS'(1)
		|-> rem_w[INDEX_BITS] == '0)
		else $error("ftc_dim_pass: nonzero remainder for unit divisor");

	// A zero size ends the running index
	a_zero_size_run: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && divisor == '0 |-> dn_run == '0)
		else $error("ftc_dim_pass: running index kept after zero size");

endmodule

`default_nettype wire

// ===== rtl/core/flat_index_to_coords.sv =====
// ----------------------------------------------------------------------------
// flat_index_to_coords: row-major flat index to coordinate converter
//
// Takes one flat index per item on index_ch and returns the coordinates along
// up to four dimensions on coord_ch. Dimension sizes and the number of active
// dimensions come from the write port (cfg_we, cfg_index, cfg_data); write
// them only while no item is in flight. The innermost active dimension is
// split off first; the quotient left after dimension zero is dropped, so
// coord0 wraps. Inactive coordinates read as zero.
//
// Each dimension is a pipelined restoring divider, one quotient bit per
// stage. The pipeline is the division stages plus the output register.
// Throughput is one item per cycle while coord_ch does not stall.
//
// When the receiver holds coord_ch.ready low with a result waiting, the whole
// pipeline freezes and index_ch.ready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads four active dimensions of size one.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_index_to_coords #(
	parameter int INDEX_BITS = ftc_pkg::INDEX_BITS_DEF,
	parameter int COORD_BITS = ftc_pkg::COORD_BITS_DEF,
	localparam int CfgBits   = (COORD_BITS > ftc_pkg::NUM_DIMS_BITS) ?
		COORD_BITS : ftc_pkg::NUM_DIMS_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ftc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CfgBits-1:0]                 cfg_data,
	ftc_index_if.sink                          index_ch,
	ftc_coord_if.source                        coord_ch
);
	import ftc_pkg::*;

	logic [NUM_DIMS_BITS-1:0]             num_dims_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] size_q;
	logic [NUM_DIMS_BITS-1:0]             active;
	logic [MAX_DIMS-1:0]                  dim_on;
	logic [COORD_BITS-1:0]                div_w   [MAX_DIMS];

	logic                                 valid_w [MAX_DIMS+1];
	logic [INDEX_BITS-1:0]                run_w   [MAX_DIMS+1];
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_w [MAX_DIMS+1];

	logic                                 adv;
	logic                                 out_valid_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] out_coord_q;

	// Take configuration writes; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= NUM_DIMS_RESET;
			for (int i = 0; i < MAX_DIMS; i++) begin
				size_q[i] <= COORD_BITS'(1);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_DIMS:  num_dims_q <= cfg_data[NUM_DIMS_BITS-1:0];
				REG_SIZE_DIM0: size_q[0]  <= cfg_data[COORD_BITS-1:0];
				REG_SIZE_DIM1: size_q[1]  <= cfg_data[COORD_BITS-1:0];
				REG_SIZE_DIM2: size_q[2]  <= cfg_data[COORD_BITS-1:0];
				REG_SIZE_DIM3: size_q[3]  <= cfg_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the dimension count to one through MAX_DIMS
	always_comb begin
		priority if (num_dims_q == '0) begin
			active = NUM_DIMS_BITS'(1);
		end else if (num_dims_q > NUM_DIMS_BITS'(MAX_DIMS)) begin
			active = NUM_DIMS_BITS'(MAX_DIMS);
		end else begin
			active = num_dims_q;
		end
	end

	// Inactive dimensions divide by one, which leaves a zero coordinate
	for (genvar i = 0; i < MAX_DIMS; i++) begin : g_on
		assign dim_on[i] = (NUM_DIMS_BITS'(i) < active);
	end

	// Freeze the whole pipeline while a result waits on a stalled receiver
	assign adv            = !out_valid_q || coord_ch.ready;
	assign index_ch.ready = adv;

	assign valid_w[0] = index_ch.valid;
	assign run_w[0]   = index_ch.flat_index;
	assign coord_w[0] = '0;

	// Innermost dimension first, dimension zero last
	for (genvar p = 0; p < MAX_DIMS; p++) begin : g_pass
		localparam int D = MAX_DIMS - 1 - p;

		assign div_w[p] = dim_on[D] ? size_q[D] : COORD_BITS'(1);

		ftc_dim_pass #(
			.COORD_BITS (COORD_BITS),
			.INDEX_BITS (INDEX_BITS),
			.DIM        (D)
		) u_pass (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (div_w[p]),
			.up_valid (valid_w[p]),
			.up_run   (run_w[p]),
			.up_coord (coord_w[p]),
			.dn_valid (valid_w[p+1]),
			.dn_run   (run_w[p+1]),
			.dn_coord (coord_w[p+1])
		);
	end

	// Output register; the leftover quotient is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_w[MAX_DIMS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_coord_q <= coord_w[MAX_DIMS];
		end
	end

	assign coord_ch.valid  = out_valid_q;
	assign coord_ch.coord0 = out_coord_q[0];
	assign coord_ch.coord1 = out_coord_q[1];
	assign coord_ch.coord2 = out_coord_q[2];
	assign coord_ch.coord3 = out_coord_q[3];

	// Coordinates of active dimensions stay within their size
	for (genvar i = 0; i < MAX_DIMS; i++) begin : g_chk
		a_coord_in_range: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_q && dim_on[i] && size_q[i] != '0
			|-> out_coord_q[i] < size_q[i])
			else $error("flat_index_to_coords: coordinate out of range");

		a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_q && !dim_on[i] |-> out_coord_q[i] == '0)
			else $error("flat_index_to_coords: inactive coordinate not zero");
	end

	// No item enters while a result is stuck at the output
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		index_ch.valid && index_ch.ready |-> !coord_ch.valid || coord_ch.ready)
		else $error("flat_index_to_coords: item accepted during output stall");

endmodule

`default_nettype wire
